>>> rtl/ghp_pkg.sv
// ghp_pkg: shared types, codes and helpers for the response header parser
// used by ghp_step, ghp_outq and gemini_response_header_parser_core
// no dependencies
`default_nettype none

package ghp_pkg;

    // result queue depth default, power of two, at least 2
    localparam int OUT_DEPTH_DEF = 4;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam int IDX_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_META_LIMIT = 2'd1;

    localparam logic [IDX_W-1:0] META_LIMIT_RST = 11'd1024;
    localparam logic [IDX_W-1:0] META_LIMIT_MAX = 11'd2040;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [3:0] OC_INPUT = 4'd0;
    localparam logic [3:0] OC_SUCCESS = 4'd1;
    localparam logic [3:0] OC_REDIRECT = 4'd2;
    localparam logic [3:0] OC_TEMPORARY = 4'd3;
    localparam logic [3:0] OC_NOT_FOUND = 4'd4;
    localparam logic [3:0] OC_AUTH = 4'd5;
    localparam logic [3:0] OC_UNSUPPORTED = 4'd6;
    localparam logic [3:0] OC_PROTOCOL = 4'd7;
    localparam logic [3:0] OC_EARLY = 4'd8;
    localparam logic [3:0] OC_NORMAL = 4'd9;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DONE   = 2'd2,
        PH_CLOSED = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        KIND_META = 3'd0,
        KIND_HEND = 3'd1,
        KIND_BODY = 3'd2,
        KIND_FAIL = 3'd3,
        KIND_END  = 3'd4
    } t_kind;

    // lowest field last in declaration so it lands in the low bits
    typedef struct packed {
        logic       meta_empty;
        logic [3:0] outcome;
        logic [3:0] status_units;
        logic [3:0] status_tens;
        logic [7:0] out_byte;
    } t_res_data;

    typedef struct packed {
        t_kind     kind;
        t_res_data data;
    } t_result;

    typedef struct packed {
        t_phase           phase;
        logic [IDX_W-1:0] byte_index;
        logic [3:0]       first_digit;
        logic [3:0]       second_digit;
        logic             prefix_bad;
        logic             cr_pending;
        logic             meta_seen;
    } t_state;

    typedef struct packed {
        t_state     nxt;
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

    function automatic logic [3:0] outcome_of(input logic [3:0] digit);
        logic [3:0] oc;
        unique case (digit)
            4'd1:    oc = OC_INPUT;
            4'd2:    oc = OC_SUCCESS;
            4'd3:    oc = OC_REDIRECT;
            4'd4:    oc = OC_TEMPORARY;
            4'd5:    oc = OC_NOT_FOUND;
            4'd6:    oc = OC_AUTH;
            default: oc = OC_UNSUPPORTED;
        endcase
        return oc;
    endfunction

    function automatic t_result mk_result(input t_kind kind, input logic [7:0] b,
                                          input logic [3:0] oc);
        t_result r;
        r.kind = kind;
        r.data = '0;
        r.data.out_byte = b;
        r.data.outcome = oc;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ghp_step.sv
// ghp_step: next-state and result logic for one accepted item
// depends on ghp_pkg
`default_nettype none

module ghp_step (
    input  wire ghp_pkg::t_state               i_state,
    input  wire                                i_header_enable,
    input  wire [ghp_pkg::IDX_W-1:0]           i_meta_limit,
    input  wire                                i_mode,
    input  wire [7:0]                          i_byte,
    output ghp_pkg::t_step                     o_step
);

    logic [ghp_pkg::IDX_W-1:0] lim;
    logic [ghp_pkg::IDX_W:0]   lim_end;
    logic [ghp_pkg::IDX_W-1:0] idx;
    logic                      is_digit;
    logic                      cr_meta;
    ghp_pkg::t_result          verdict;

    assign idx = i_state.byte_index;
    assign lim = (i_meta_limit > ghp_pkg::META_LIMIT_MAX) ? ghp_pkg::META_LIMIT_MAX
                                                           : i_meta_limit;
    assign lim_end = {1'b0, lim} + (ghp_pkg::IDX_W+1)'(4);
    assign is_digit = (i_byte >= ghp_pkg::CH_ZERO) && (i_byte <= ghp_pkg::CH_NINE);

    always_comb begin
        verdict = ghp_pkg::mk_result(ghp_pkg::KIND_HEND, 8'd0,
                                     ghp_pkg::outcome_of(i_state.first_digit));
        verdict.data.status_tens = i_state.first_digit;
        verdict.data.status_units = i_state.second_digit;
        verdict.data.meta_empty = ~i_state.meta_seen;
    end

    always_comb begin
        o_step.nxt = i_state;
        o_step.count = 2'd0;
        o_step.res0 = '0;
        o_step.res1 = '0;
        cr_meta = 1'b0;
        if (i_mode) begin
            if (i_state.phase != ghp_pkg::PH_CLOSED) begin
                o_step.nxt.phase = ghp_pkg::PH_CLOSED;
                o_step.nxt.cr_pending = 1'b0;
                if (i_state.phase == ghp_pkg::PH_HEADER && i_header_enable) begin
                    o_step.res0 = ghp_pkg::mk_result(ghp_pkg::KIND_FAIL, 8'd0,
                                                     ghp_pkg::OC_EARLY);
                    o_step.res1 = ghp_pkg::mk_result(ghp_pkg::KIND_END, 8'd0,
                                                     ghp_pkg::OC_EARLY);
                    o_step.count = 2'd2;
                end else begin
                    o_step.res0 = ghp_pkg::mk_result(ghp_pkg::KIND_END, 8'd0,
                                                     ghp_pkg::OC_NORMAL);
                    o_step.count = 2'd1;
                end
            end
        end else if (i_state.phase == ghp_pkg::PH_BODY ||
                     (i_state.phase == ghp_pkg::PH_HEADER && !i_header_enable)) begin
            o_step.res0 = ghp_pkg::mk_result(ghp_pkg::KIND_BODY, i_byte, 4'd0);
            o_step.count = 2'd1;
        end else if (i_state.phase == ghp_pkg::PH_HEADER) begin
            if ({1'b0, idx} >= lim_end) begin
                // header too long: failure alone, byte and held cr dropped
                o_step.nxt.phase = ghp_pkg::PH_DONE;
                o_step.nxt.cr_pending = 1'b0;
                o_step.res0 = ghp_pkg::mk_result(ghp_pkg::KIND_FAIL, 8'd0,
                                                 ghp_pkg::OC_PROTOCOL);
                o_step.count = 2'd1;
            end else if (i_state.cr_pending && i_byte == ghp_pkg::CH_LF) begin
                o_step.nxt.cr_pending = 1'b0;
                o_step.count = 2'd1;
                if (idx < ghp_pkg::IDX_W'(3) || i_state.prefix_bad) begin
                    o_step.nxt.phase = ghp_pkg::PH_DONE;
                    o_step.res0 = ghp_pkg::mk_result(ghp_pkg::KIND_FAIL, 8'd0,
                                                     ghp_pkg::OC_PROTOCOL);
                end else begin
                    o_step.nxt.phase = (i_state.first_digit == 4'd2) ? ghp_pkg::PH_BODY
                                                                     : ghp_pkg::PH_DONE;
                    o_step.res0 = verdict;
                end
            end else begin
                // held cr that was not followed by lf
                if (i_state.cr_pending) begin
                    if (idx == ghp_pkg::IDX_W'(3)) begin
                        o_step.nxt.prefix_bad = 1'b1;
                    end else if (idx >= ghp_pkg::IDX_W'(4)) begin
                        o_step.nxt.meta_seen = 1'b1;
                        o_step.res0 = ghp_pkg::mk_result(ghp_pkg::KIND_META,
                                                         ghp_pkg::CH_CR, 4'd0);
                        cr_meta = 1'b1;
                    end
                end
                if (idx < ghp_pkg::IDX_W'(2)) begin
                    if (!is_digit) begin
                        o_step.nxt.prefix_bad = 1'b1;
                    end else if (idx == '0) begin
                        o_step.nxt.first_digit = i_byte[3:0];
                    end else begin
                        o_step.nxt.second_digit = i_byte[3:0];
                    end
                end
                o_step.nxt.cr_pending = (i_byte == ghp_pkg::CH_CR);
                if (i_byte != ghp_pkg::CH_CR) begin
                    if (idx == ghp_pkg::IDX_W'(2)) begin
                        if (i_byte != ghp_pkg::CH_SPACE && i_byte != ghp_pkg::CH_TAB) begin
                            o_step.nxt.prefix_bad = 1'b1;
                        end
                    end else if (idx >= ghp_pkg::IDX_W'(3)) begin
                        o_step.nxt.meta_seen = 1'b1;
                        if (cr_meta) begin
                            o_step.res1 = ghp_pkg::mk_result(ghp_pkg::KIND_META,
                                                             i_byte, 4'd0);
                        end else begin
                            o_step.res0 = ghp_pkg::mk_result(ghp_pkg::KIND_META,
                                                             i_byte, 4'd0);
                        end
                    end
                end
                o_step.count = 2'({1'b0, cr_meta}) +
                               2'({1'b0, (i_byte != ghp_pkg::CH_CR &&
                                          idx >= ghp_pkg::IDX_W'(3))});
                o_step.nxt.byte_index = idx + ghp_pkg::IDX_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/ghp_outq.sv
// ghp_outq: small result queue, takes up to two results per cycle, gives one
// depends on ghp_pkg
`default_nettype none

module ghp_outq #(
    parameter int DEPTH = ghp_pkg::OUT_DEPTH_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire [1:0]          i_push_count,
    input  wire ghp_pkg::t_result i_res0,
    input  wire ghp_pkg::t_result i_res1,
    output logic               o_room,
    output logic               o_valid,
    input  wire                i_ready,
    output ghp_pkg::t_result   o_res,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ghp_pkg::t_result    r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic [PTR_W-1:0]    n_wr_ptr;
    logic [PTR_W-1:0]    n_rd_ptr;
    logic [CNT_W-1:0]    n_count;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign o_res = r_mem[r_rd_ptr];
    assign o_room = (r_count <= CNT_W'(DEPTH - 2));
    assign o_count = r_count;
    assign pop = o_valid & i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push_count);
        n_rd_ptr = r_rd_ptr + PTR_W'(pop);
        n_count = r_count + CNT_W'(i_push_count) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_res1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/gemini_response_header_parser_core.sv
// gemini_response_header_parser_core: streaming parser for the reply header
// depends on ghp_pkg, ghp_step, ghp_outq
//
// usage:
//   slave side takes one item per cycle while tready is high: a received
//   byte (tuser 0) or a connection-closed event (tuser 1). tdata is the byte.
//   master side gives results: tuser is the kind (meta byte, header end,
//   body byte, failure, stream end), tdata carries byte, status digits,
//   outcome and the empty-meta flag.
//   config channel writes header_enable (index 0) and meta_limit (index 1)
//   at any cycle it is valid; write it only while the parser is idle.
// a result is registered in the result queue when its item is accepted.
//   throughput: one item per cycle while each item yields at most one
//   result and the master side keeps up; an item that yields two (held cr
//   plus a meta byte, or an early close) gives them out one at a time. the
//   result queue depth sets how much stall on the master side is absorbed.
// reset: parser returns to header phase, queue empties, header_enable = 1,
//   meta_limit = 1024.
// stall: tready on the slave side drops when the queue cannot hold two more
//   results; nothing is lost or repeated.
`default_nettype none

module gemini_response_header_parser_core #(
    parameter int OUT_DEPTH = ghp_pkg::OUT_DEPTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // slave side
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    input  wire  [7:0]                        i_s_tdata,  // [7:0] data_byte
    input  wire                               i_s_tuser,  // [0] mode
    // master side
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    // [7:0] out_byte, [11:8] status_tens, [15:12] status_units,
    // [19:16] outcome, [20] meta_empty, [23:21] zero
    output logic [23:0]                       o_m_tdata,
    output logic [2:0]                        o_m_tuser,  // [2:0] kind
    // config write
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [ghp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [ghp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    // parsing state and config
    ghp_pkg::t_state              r_state;
    logic                         r_header_enable;
    logic [ghp_pkg::IDX_W-1:0]    r_meta_limit;

    ghp_pkg::t_step               step;
    ghp_pkg::t_result             q_res;
    logic                         s_accept;
    logic [1:0]                   push_count;
    logic                         q_room;
    logic [CNT_W-1:0]             q_count;

    assign o_s_tready = q_room;
    assign s_accept = i_s_tvalid & o_s_tready;
    assign push_count = s_accept ? step.count : 2'd0;
    assign o_cfg_ready = 1'b1;

    ghp_step u_step (
        .i_state         (r_state),
        .i_header_enable (r_header_enable),
        .i_meta_limit    (r_meta_limit),
        .i_mode          (i_s_tuser),
        .i_byte          (i_s_tdata),
        .o_step          (step)
    );

    // result queue, parts the slave side from the master side
    ghp_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_res0       (step.res0),
        .i_res1       (step.res1),
        .o_room       (q_room),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_res        (q_res),
        .o_count      (q_count)
    );

    assign o_m_tdata = {3'b000, q_res.data};
    assign o_m_tuser = q_res.kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: ghp_pkg::PH_HEADER, default: '0};
        end else if (s_accept) begin
            r_state <= step.nxt;
        end
    end

    // config writes leave the parsing state alone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_enable <= 1'b1;
            r_meta_limit <= ghp_pkg::META_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == ghp_pkg::CFG_HEADER_ENABLE) begin
                r_header_enable <= i_cfg_data[0];
            end else if (i_cfg_index == ghp_pkg::CFG_META_LIMIT) begin
                r_meta_limit <= i_cfg_data;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // queue never holds more than its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CNT_W'(OUT_DEPTH))
        else $error("result queue overflow");

    // once closed, nothing more comes out of the parser
    a_closed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_state.phase == ghp_pkg::PH_CLOSED) |-> (push_count == 2'd0))
        else $error("result after close");

    // an accepted close event leaves the parser closed
    a_close_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tuser) |=> (r_state.phase == ghp_pkg::PH_CLOSED))
        else $error("close did not close");

    // a held cr only exists while the header is being parsed
    a_cr_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.cr_pending |-> (r_state.phase == ghp_pkg::PH_HEADER))
        else $error("held cr outside header");
`endif

endmodule

`default_nettype wire
